### hw/rtl/sfdl_pkg.sv
// Shared types and constants of the smoothed fractional delay line.
package sfdl_pkg;

  // Fixed field widths
  localparam int TARGET_BITS    = 20;
  localparam int STEPS_BITS     = 16;
  localparam int RAMP_FRAC_BITS = 12;
  localparam int APB_DATA_BITS  = 32;
  localparam int APB_ADDR_BITS  = 3;

  // Register indexes (word address bit 2)
  typedef enum logic {
    REG_RAMP_STEPS  = 1'b0,
    REG_STEREO_MODE = 1'b1
  } reg_idx_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TGT,
    ST_DIV,
    ST_DFIN,
    ST_ADV,
    ST_POS,
    ST_RD0,
    ST_RD1,
    ST_SUB,
    ST_MUL,
    ST_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr;       // write zero at clear pointer
    logic load;      // capture input request
    logic tgt_upd;   // evaluate target change
    logic div_step;  // one quotient bit
    logic div_fin;   // apply sign, store increment
    logic adv;       // advance glide
    logic pos_wr;    // read point, write samples
    logic rd0;       // read first tap
    logic rd1;       // read second tap
    logic sub;       // tap difference
    logic mul;       // fraction product
    logic out_load;  // fill output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic tgt_chg;
    logic ramp_zero;
    logic div_last;
    logic out_busy;
  } sts_t;

endpackage

### hw/rtl/sfdl_ctrl.sv
// Sequencer for the smoothed fractional delay line.
module sfdl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  sfdl_pkg::sts_t  sts,
  output sfdl_pkg::cmd_t  cmd
);
  import sfdl_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_TGT;
      ST_TGT: begin
        if (sts.tgt_chg && !sts.ramp_zero) state_nxt = ST_DIV;
        else state_nxt = ST_ADV;
      end
      ST_DIV:   if (sts.div_last) state_nxt = ST_DFIN;
      ST_DFIN:  state_nxt = ST_ADV;
      ST_ADV:   state_nxt = ST_POS;
      ST_POS:   state_nxt = ST_RD0;
      ST_RD0:   state_nxt = ST_RD1;
      ST_RD1:   state_nxt = ST_SUB;
      ST_SUB:   state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_FIN;
      ST_FIN:   if (!sts.out_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_TGT:   cmd.tgt_upd  = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_DFIN:  cmd.div_fin  = 1'b1;
      ST_ADV:   cmd.adv      = 1'b1;
      ST_POS:   cmd.pos_wr   = 1'b1;
      ST_RD0:   cmd.rd0      = 1'b1;
      ST_RD1:   cmd.rd1      = 1'b1;
      ST_SUB:   cmd.sub      = 1'b1;
      ST_MUL:   cmd.mul      = 1'b1;
      ST_FIN:   cmd.out_load = !sts.out_busy;
      default:  cmd = '0;
    endcase
  end

endmodule

### hw/rtl/sfdl_datapath.sv
// Datapath: glide state, ramp divider, ring stores, interpolation, output register.
module sfdl_datapath #(
  parameter int RING_DEPTH      = 4096,
  parameter int SAMPLE_BITS     = 24,
  parameter int DELAY_FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [SAMPLE_BITS-1:0]         in_left,
  input  logic signed [SAMPLE_BITS-1:0]         in_right,
  input  logic [sfdl_pkg::TARGET_BITS-1:0]      in_target,
  input  logic [sfdl_pkg::STEPS_BITS-1:0]       ramp_steps,
  input  logic                                  stereo_mode,
  input  sfdl_pkg::cmd_t                        cmd,
  output sfdl_pkg::sts_t                        sts,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_BITS-1:0]         out_left,
  output logic signed [SAMPLE_BITS-1:0]         out_right
);
  import sfdl_pkg::*;

  localparam int AW   = $clog2(RING_DEPTH);
  localparam int PW   = AW + DELAY_FRAC_BITS;
  localparam int CW   = PW + RAMP_FRAC_BITS;
  localparam int FW   = (DELAY_FRAC_BITS == 0) ? 1 : DELAY_FRAC_BITS;
  localparam int XW   = (PW > TARGET_BITS) ? PW : TARGET_BITS;
  localparam int DCW  = $clog2(CW);
  localparam int SB   = SAMPLE_BITS;
  localparam int PRW  = SB + FW + 2;
  localparam logic [PW-1:0]  MAX_D   = PW'(64'(RING_DEPTH - 2) << DELAY_FRAC_BITS);
  localparam logic [XW-1:0]  MAX_X   = XW'(MAX_D);
  localparam logic [PW:0]    SPAN    = (PW+1)'(64'(RING_DEPTH) << DELAY_FRAC_BITS);
  localparam logic [AW-1:0]  LAST_IX = AW'(RING_DEPTH - 1);
  localparam logic [DCW-1:0] DIV_END = DCW'(CW - 1);

  // Ring stores
  logic signed [SB-1:0] ring_l [RING_DEPTH];
  logic signed [SB-1:0] ring_r [RING_DEPTH];

  // Captured request
  logic signed [SB-1:0]   l_in_r, r_in_r;
  logic [TARGET_BITS-1:0] tgt_r;

  // Glide state
  logic [TARGET_BITS-1:0] latched_r;
  logic [CW-1:0]          cur_r;
  logic signed [CW:0]     inc_r;
  logic [STEPS_BITS-1:0]  steps_r;

  // Divider
  logic [CW-1:0]         dvd_r;
  logic [STEPS_BITS-1:0] rem_r;
  logic                  neg_r;
  logic [DCW-1:0]        div_cnt_r;

  // Addressing
  logic [AW-1:0] wi_r, clr_idx_r, i0_r, i1_r;
  logic [FW-1:0] frac_r;

  // Interpolation pipeline
  logic signed [SB-1:0]  rdl_r, rdr_r, r0l_r, r0r_r;
  logic signed [SB:0]    dl_r, dr_r;
  logic signed [PRW-1:0] pl_r, pr_r;

  // Output register
  logic                 out_valid_r;
  logic signed [SB-1:0] out_l_r, out_r_r;

  // Combinational helpers
  logic [XW-1:0]           tgt_x, tgt_sat;
  logic [CW-1:0]           tgt_full, lat_full, mag;
  logic [CW-1:0]           cur_add;
  logic [STEPS_BITS:0]     rem_sh;
  logic                    ge;
  logic [PW-1:0]           d_raw, d_cl, base, pos;
  logic [PW:0]             pos_wrap;
  logic [AW-1:0]           i0_nxt;
  logic signed [FW:0]      frac_s;
  logic signed [PRW-1:0]   shl, shr;
  logic                    wr_l, wr_r, rd_en;
  logic [AW-1:0]           wa, ra;
  logic signed [SB-1:0]    wdl, wdr;

  // Target saturation
  assign tgt_x   = XW'(in_target);
  assign tgt_sat = (tgt_x > MAX_X) ? MAX_X : tgt_x;

  // Glide arithmetic
  assign tgt_full = CW'(tgt_r) << RAMP_FRAC_BITS;
  assign lat_full = CW'(latched_r) << RAMP_FRAC_BITS;
  assign mag      = (tgt_full >= cur_r) ? (tgt_full - cur_r) : (cur_r - tgt_full);
  assign cur_add  = CW'($signed({1'b0, cur_r}) + inc_r);

  // Restoring divider step
  assign rem_sh = {rem_r, dvd_r[CW-1]};
  assign ge     = (rem_sh >= {1'b0, steps_r});

  // Read point
  assign d_raw    = cur_r[CW-1:RAMP_FRAC_BITS];
  assign d_cl     = (d_raw > MAX_D) ? MAX_D : d_raw;
  assign base     = PW'(wi_r) << DELAY_FRAC_BITS;
  assign pos_wrap = {1'b0, base} + SPAN - {1'b0, d_cl};
  assign pos      = (base >= d_cl) ? (base - d_cl) : PW'(pos_wrap);
  assign i0_nxt   = pos[PW-1:DELAY_FRAC_BITS];

  // Interpolation terms
  assign frac_s = {1'b0, frac_r};
  assign shl    = pl_r >>> DELAY_FRAC_BITS;
  assign shr    = pr_r >>> DELAY_FRAC_BITS;

  // Memory port control
  assign wr_l  = cmd.clr || cmd.pos_wr;
  assign wr_r  = cmd.clr || (cmd.pos_wr && stereo_mode);
  assign wa    = cmd.clr ? clr_idx_r : wi_r;
  assign wdl   = cmd.clr ? '0 : l_in_r;
  assign wdr   = cmd.clr ? '0 : r_in_r;
  assign rd_en = cmd.rd0 || cmd.rd1;
  assign ra    = cmd.rd1 ? i1_r : i0_r;

  always_ff @(posedge clk) begin
    if (wr_l) ring_l[wa] <= wdl;
    if (rd_en) rdl_r <= ring_l[ra];
  end

  always_ff @(posedge clk) begin
    if (wr_r) ring_r[wa] <= wdr;
    if (rd_en) rdr_r <= ring_r[ra];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r   <= '0;
      cur_r       <= '0;
      inc_r       <= '0;
      steps_r     <= '0;
      div_cnt_r   <= '0;
      wi_r        <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_idx_r <= (clr_idx_r == LAST_IX) ? '0 : clr_idx_r + 1'b1;
      // target change: jump or start a glide
      if (cmd.tgt_upd && (tgt_r != latched_r)) begin
        latched_r <= tgt_r;
        if (ramp_steps == '0) begin
          cur_r   <= tgt_full;
          steps_r <= '0;
        end else begin
          steps_r   <= ramp_steps;
          div_cnt_r <= '0;
        end
      end
      if (cmd.div_step) div_cnt_r <= div_cnt_r + 1'b1;
      if (cmd.div_fin) inc_r <= neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});
      // glide advance
      if (cmd.adv && (steps_r != '0)) begin
        steps_r <= steps_r - 1'b1;
        cur_r   <= (steps_r == STEPS_BITS'(1)) ? lat_full : cur_add;
      end
      if (cmd.sub) wi_r <= (wi_r == LAST_IX) ? '0 : wi_r + 1'b1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      l_in_r <= in_left;
      r_in_r <= in_right;
      tgt_r  <= TARGET_BITS'(tgt_sat);
    end
    if (cmd.tgt_upd) begin
      dvd_r <= mag;
      rem_r <= '0;
      neg_r <= (tgt_full < cur_r);
    end
    if (cmd.div_step) begin
      dvd_r <= {dvd_r[CW-2:0], ge};
      rem_r <= ge ? STEPS_BITS'(rem_sh - {1'b0, steps_r}) : rem_sh[STEPS_BITS-1:0];
    end
    if (cmd.pos_wr) begin
      i0_r   <= i0_nxt;
      i1_r   <= (i0_nxt == LAST_IX) ? '0 : i0_nxt + 1'b1;
      frac_r <= (DELAY_FRAC_BITS == 0) ? '0 : pos[FW-1:0];
    end
    if (cmd.rd1) begin
      r0l_r <= rdl_r;
      r0r_r <= rdr_r;
    end
    if (cmd.sub) begin
      dl_r <= (SB+1)'(rdl_r) - (SB+1)'(r0l_r);
      dr_r <= (SB+1)'(rdr_r) - (SB+1)'(r0r_r);
    end
    if (cmd.mul) begin
      pl_r <= dl_r * frac_s;
      pr_r <= dr_r * frac_s;
    end
    if (cmd.out_load) begin
      out_l_r <= SB'(PRW'(r0l_r) + shl);
      out_r_r <= stereo_mode ? SB'(PRW'(r0r_r) + shr) : r_in_r;
    end
  end

  // Status
  always_comb begin
    sts.clr_last  = (clr_idx_r == LAST_IX);
    sts.tgt_chg   = (tgt_r != latched_r);
    sts.ramp_zero = (ramp_steps == '0);
    sts.div_last  = (div_cnt_r == DIV_END);
    sts.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_l_r;
  assign out_right = out_r_r;

endmodule

### hw/rtl/smoothed_fractional_delay_line_core.sv
// Each request passes capture, target check, a ramp divide on a glide start, glide advance,
// read point, two tap reads, difference, product and output load; the divider gives one bit a cycle.
// A request is taken only once the previous one is through; the next request is taken while the
// previous result waits in the output register.
// Reset: synchronous, active low; afterwards both ring stores are zeroed by a clearing pass over
// all RING_DEPTH entries (4096 by default) during which no request is taken; registers stay writable.
module smoothed_fractional_delay_line_core #(
  parameter int RING_DEPTH      = 4096,
  parameter int SAMPLE_BITS     = 24,
  parameter int DELAY_FRAC_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  // Input stream
  input  logic in_tvalid,
  output logic in_tready,
  // tdata: left_in, right_in, target_delay, zero fill
  input  logic [((2*SAMPLE_BITS+sfdl_pkg::TARGET_BITS+7)/8)*8-1:0] in_tdata,
  // Result stream
  output logic out_tvalid,
  input  logic out_tready,
  // tdata: left_out, right_out, zero fill
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  // Register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sfdl_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [sfdl_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [sfdl_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                pready
);
  import sfdl_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int OUT_W = ((2*SAMPLE_BITS+7)/8)*8;

  logic [STEPS_BITS-1:0] ramp_steps_r;
  logic                  stereo_mode_r;
  logic                  wr_en;
  reg_idx_t              reg_idx;
  cmd_t                  cmd;
  sts_t                  sts;
  logic signed [SB-1:0]  out_l, out_r;

  // Register file
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_steps_r  <= STEPS_BITS'(1024);
      stereo_mode_r <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RAMP_STEPS:  ramp_steps_r  <= pwdata[STEPS_BITS-1:0];
        REG_STEREO_MODE: stereo_mode_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_RAMP_STEPS:  prdata = APB_DATA_BITS'(ramp_steps_r);
      REG_STEREO_MODE: prdata = APB_DATA_BITS'(stereo_mode_r);
      default:         prdata = '0;
    endcase
  end

  sfdl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfdl_datapath #(
    .RING_DEPTH      (RING_DEPTH),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .DELAY_FRAC_BITS (DELAY_FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_left     (in_tdata[SB-1:0]),
    .in_right    (in_tdata[2*SB-1:SB]),
    .in_target   (in_tdata[2*SB+TARGET_BITS-1:2*SB]),
    .ramp_steps  (ramp_steps_r),
    .stereo_mode (stereo_mode_r),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_left    (out_l),
    .out_right   (out_r)
  );

  // Result packing
  assign out_tdata = OUT_W'({out_r, out_l});

endmodule

### verif/tb_smoothed_fractional_delay_line_core.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the smoothed fractional delay line core.
module tb_smoothed_fractional_delay_line_core;
  import sfdl_pkg::*;

  localparam int RING_DEPTH      = 4096;
  localparam int SAMPLE_BITS     = 24;
  localparam int DELAY_FRAC_BITS = 8;
  localparam int IN_BITS         = ((2*SAMPLE_BITS+TARGET_BITS+7)/8)*8;
  localparam int OUT_BITS        = ((2*SAMPLE_BITS+7)/8)*8;
  localparam longint MAX_DELAY   = longint'(RING_DEPTH - 2) << DELAY_FRAC_BITS;
  localparam longint RING_SPAN   = longint'(RING_DEPTH) << DELAY_FRAC_BITS;
  localparam int PHASE_FRAMES    = 188;

  // One input request, first field in the low bits
  typedef struct packed {
    logic [TARGET_BITS-1:0]        target;
    logic signed [SAMPLE_BITS-1:0] right;
    logic signed [SAMPLE_BITS-1:0] left;
  } frame_t;

  // One result
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] right;
    logic signed [SAMPLE_BITS-1:0] left;
  } audio_t;

  // Receiver back-pressure patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [IN_BITS-1:0]        in_tdata   = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_BITS-1:0]       out_tdata;
  logic                      psel       = 1'b0;
  logic                      penable    = 1'b0;
  logic                      pwrite     = 1'b0;
  logic [APB_ADDR_BITS-1:0]  paddr      = '0;
  logic [APB_DATA_BITS-1:0]  pwdata     = '0;
  logic [APB_DATA_BITS-1:0]  prdata;
  logic                      pready;

  smoothed_fractional_delay_line_core #(
    .RING_DEPTH      (RING_DEPTH),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .DELAY_FRAC_BITS (DELAY_FRAC_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #4 clk = ~clk;

  // Shadow of the delay line state and registers
  logic signed [SAMPLE_BITS-1:0] left_hist  [RING_DEPTH];
  logic signed [SAMPLE_BITS-1:0] right_hist [RING_DEPTH];
  int unsigned wr_ptr;
  longint      glide_pos;    // delay in 1/256 sample with RAMP_FRAC_BITS extra bits
  longint      glide_step;
  int unsigned glide_left;
  longint      held_target;
  int unsigned ramp_len;
  bit          stereo_on;

  frame_t pending_frames[$];
  audio_t expected_audio[$];
  int     mismatches;
  int     frames_sent;
  int     results_seen;
  int     settings_used;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Linear interpolation between two taps, floored
  function automatic logic signed [SAMPLE_BITS-1:0] interp(longint r0, longint r1,
                                                             longint frac);
    longint prod;
    prod = frac * (r1 - r0);
    return SAMPLE_BITS'(r0 + (prod >>> DELAY_FRAC_BITS));
  endfunction

  // Advance the shadow by one frame and return the delayed output
  function automatic audio_t delay_frame(frame_t f);
    longint      tgt, dly, base, pos, frac;
    int unsigned i0, i1;
    audio_t      res;
    tgt = longint'(f.target);
    if (tgt > MAX_DELAY) tgt = MAX_DELAY;
    // new target: jump or start a glide
    if (tgt != held_target) begin
      held_target = tgt;
      if (ramp_len == 0) begin
        glide_pos  = tgt << RAMP_FRAC_BITS;
        glide_left = 0;
      end else begin
        glide_step = ((tgt << RAMP_FRAC_BITS) - glide_pos) / longint'(ramp_len);
        glide_left = ramp_len;
      end
    end
    // glide advance, landing exactly on the target
    if (glide_left != 0) begin
      glide_left--;
      if (glide_left == 0) glide_pos = held_target << RAMP_FRAC_BITS;
      else glide_pos += glide_step;
    end
    dly = glide_pos >> RAMP_FRAC_BITS;
    if (dly > MAX_DELAY) dly = MAX_DELAY;
    base = longint'(wr_ptr) << DELAY_FRAC_BITS;
    pos  = (base >= dly) ? base - dly : base + RING_SPAN - dly;
    i0   = (pos >> DELAY_FRAC_BITS) % RING_DEPTH;
    i1   = (i0 + 1) % RING_DEPTH;
    frac = pos & ((longint'(1) << DELAY_FRAC_BITS) - 1);
    left_hist[wr_ptr] = f.left;
    res.left = interp(left_hist[i0], left_hist[i1], frac);
    if (stereo_on) begin
      right_hist[wr_ptr] = f.right;
      res.right = interp(right_hist[i0], right_hist[i1], frac);
    end else begin
      res.right = f.right;
    end
    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
    return res;
  endfunction

  // Sender: bursts of requests with random gaps
  frame_t in_flight;
  int     burst_left;
  int     gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_audio.push_back(delay_frame(in_flight));
        frames_sent++;
      end
      if (in_tvalid && !in_tready) begin
        // hold the request until taken
      end else if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (pending_frames.size() > 0) begin
        in_flight = pending_frames.pop_front();
        in_tdata  <= IN_BITS'(in_flight);
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: back-pressure pattern chosen at random among open, coin-flip, periodic and sparse
  rx_mode_t rx_mode;
  int       rx_mode_left;
  int       rx_tick;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      rx_mode      <= RX_OPEN;
      rx_mode_left <= 0;
      rx_tick      <= 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(20, 300);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      rx_tick <= rx_tick + 1;
      case (rx_mode)
        RX_OPEN:     out_tready <= 1'b1;
        RX_COIN:     out_tready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: out_tready <= (rx_tick % 5 == 0);
        default:     out_tready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // Result checker
  audio_t got_audio, want_audio;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_audio = audio_t'(out_tdata[2*SAMPLE_BITS-1:0]);
      results_seen++;
      if (expected_audio.size() == 0) begin
        report_mismatch($sformatf("result %h with no request pending", out_tdata));
      end else begin
        want_audio = expected_audio.pop_front();
        if (got_audio.left !== want_audio.left)
          report_mismatch($sformatf("result %0d left_out %h, want %h",
                                    results_seen, got_audio.left, want_audio.left));
        if (got_audio.right !== want_audio.right)
          report_mismatch($sformatf("result %0d right_out %h, want %h",
                                    results_seen, got_audio.right, want_audio.right));
      end
    end
  end

  // Register write then read-back; shadow follows at the write edge
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_BITS-1:0] value);
    logic [APB_DATA_BITS-1:0] back;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_RAMP_STEPS) ramp_len = 32'(value[STEPS_BITS-1:0]);
    else stereo_on = value[0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    back = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_RAMP_STEPS ? back[STEPS_BITS-1:0] !== value[STEPS_BITS-1:0]
                              : back[0] !== value[0])
      report_mismatch($sformatf("register %s reads %h, wrote %h", idx.name(), back, value));
  endtask

  task automatic set_mode(input int unsigned steps, input bit stereo);
    write_reg(REG_RAMP_STEPS, steps);
    write_reg(REG_STEREO_MODE, APB_DATA_BITS'(stereo));
    settings_used++;
  endtask

  task automatic queue_frame(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r,
                             input logic [TARGET_BITS-1:0] t);
    pending_frames.push_back('{left: l, right: r, target: t});
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    if ($urandom_range(0, 15) != 0) return SAMPLE_BITS'($urandom());
    case ($urandom_range(0, 3))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'h000000;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  // Held targets with random runs; mostly short delays so taps hit fresh samples
  task automatic queue_random_phase(input int n);
    int                     hold;
    logic [TARGET_BITS-1:0] tgt;
    hold = 0;
    tgt  = '0;
    for (int k = 0; k < n; k++) begin
      if (hold == 0) begin
        hold = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 80);
        case ($urandom_range(0, 19))
          0, 1:    tgt = '0;
          2:       tgt = TARGET_BITS'($urandom_range(MAX_DELAY - 512, (1 << TARGET_BITS) - 1));
          3, 4, 5: tgt = TARGET_BITS'($urandom());
          default: tgt = TARGET_BITS'($urandom_range(0, 64 << DELAY_FRAC_BITS));
        endcase
      end
      hold--;
      queue_frame(pick_sample(), pick_sample(), tgt);
    end
  endtask

  // Wait until all requests are taken and all results are back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_frames.size() != 0 || in_tvalid || expected_audio.size() != 0);
  endtask

  // Main sequence
  initial begin
    for (int k = 0; k < RING_DEPTH; k++) begin
      left_hist[k]  = '0;
      right_hist[k] = '0;
    end
    wr_ptr      = 0;
    glide_pos   = 0;
    glide_step  = 0;
    glide_left  = 0;
    held_target = 0;
    ramp_len    = 1024;
    stereo_on   = 1'b1;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero delay, whole and fractional taps, saturation, jumps
    set_mode(0, 1'b1);
    queue_frame(24'h7FFFFF, 24'h800000, 20'h00000);
    queue_frame(24'h800000, 24'h7FFFFF, 20'h00000);
    queue_frame(24'h000000, 24'hFFFFFF, 20'h00000);
    queue_frame(24'h7FFFFF, 24'h800000, 20'h00100);
    queue_frame(24'h800000, 24'h7FFFFF, 20'h00080);
    queue_frame(24'h7FFFFF, 24'h800000, 20'h000FF);
    queue_frame(24'h123456, 24'hEDCBA9, 20'h00001);
    queue_frame(24'h800000, 24'h7FFFFF, 20'(MAX_DELAY));
    queue_frame(24'h7FFFFF, 24'h000000, 20'hFFFFF);
    queue_frame(24'h000001, 24'hFFFFFE, 20'hFFF00);
    queue_frame(24'hFFFFFF, 24'h000001, 20'h00000);
    wait_idle();

    // Directed: short glides in mono, retarget mid-glide
    set_mode(3, 1'b0);
    queue_frame(24'h7FFFFF, 24'h800000, 20'h00300);
    queue_frame(24'h800000, 24'h7FFFFF, 20'h00300);
    queue_frame(24'h7FFFFF, 24'h800000, 20'h00300);
    queue_frame(24'h800000, 24'h7FFFFF, 20'h00300);
    queue_frame(24'h555555, 24'hAAAAAA, 20'h00000);
    queue_frame(24'hAAAAAA, 24'h555555, 20'h00280);
    queue_frame(24'h7FFFFF, 24'h800000, 20'h00280);
    queue_frame(24'h800000, 24'h7FFFFF, 20'h00280);
    queue_frame(24'h000000, 24'h000000, 20'h00280);
    wait_idle();

    // Random phases over several register settings, extremes included
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       set_mode(1024, 1'b1);
        1:       set_mode(0, 1'b1);
        2:       set_mode(1, 1'b0);
        3:       set_mode(65535, 1'b1);
        4:       set_mode($urandom_range(2, 16), 1'b1);
        5:       set_mode($urandom_range(2, 300), 1'b0);
        6:       set_mode(0, 1'b0);
        7:       set_mode(2, 1'b1);
        8:       set_mode($urandom_range(17, 5000), 1'b1);
        default: set_mode($urandom_range(1, 64), 1'b1);
      endcase
      queue_random_phase(PHASE_FRAMES);
      wait_idle();
    end

    repeat (50) @(posedge clk);
    $display("Sent %0d frames and checked %0d results across %0d register settings,",
             frames_sent, results_seen, settings_used);
    $display("covering jumps, glides, saturated targets and mono/stereo; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("Timed out with %0d requests queued and %0d results outstanding",
             pending_frames.size(), expected_audio.size());
    $display("FAILURE");
    $finish;
  end

endmodule
